[hdl/legacy_text_to_codepoint_decoder_assert.svh]
// assertion macros shared by the decoder rtl
`ifndef LEGACY_TEXT_TO_CODEPOINT_DECODER_ASSERT_SVH
`define LEGACY_TEXT_TO_CODEPOINT_DECODER_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, disabled while reset is low
`define LTCD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define LTCD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define LTCD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define LTCD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[hdl/ltcd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ltcd_pkg;

	// encoding mode codes
	localparam logic [1:0] MODE_UTF8     = 2'd0;
	localparam logic [1:0] MODE_LATIN1   = 2'd1;
	localparam logic [1:0] MODE_WIN1252  = 2'd2;
	localparam logic [1:0] MODE_MACROMAN = 2'd3;

	// special characters for newline handling
	localparam logic [20:0] CP_LF  = 21'h00000A;
	localparam logic [20:0] CP_FF  = 21'h00000C;
	localparam logic [20:0] CP_CR  = 21'h00000D;
	localparam logic [20:0] CP_NEL = 21'h000085;
	localparam logic [20:0] CP_LS  = 21'h002028;
	localparam logic [20:0] CP_PS  = 21'h002029;

	// windows code page, bytes 0x80..0x9f
	localparam logic [15:0] WIN1252_HI [32] = '{
		16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
		16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
		16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
		16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
	};

	// mac roman, bytes 0x80..0xff
	localparam logic [15:0] MACROMAN_HI [128] = '{
		16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
		16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
		16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
		16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
		16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
		16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
		16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
		16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
		16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
		16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
		16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
		16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
		16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
		16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
		16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
		16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
	};

endpackage

`default_nettype wire

[hdl/legacy_text_to_codepoint_decoder.sv]
// Byte-stream text decoder. Each accepted item is one text byte plus a
// last-byte mark; each item gives exactly one result item: a 21-bit code
// point with a char_valid flag, the string's sticky UTF-8 error flag and a
// copy of the last-byte mark. Modes: 0 UTF-8, 1 ISO Latin-1,
// 2 Windows-1252, 3 MacRoman; the user must see that the mode register is
// written only while the block is idle, which the block does not enforce.
// CR becomes LF, an LF or NEL right after a CR is dropped, and NEL, FF,
// LS and PS become LF. All decoder state clears after the last byte of a
// string. Throughput is one byte per clock while out_ready is high. A byte
// passes through the input register, then the decode step that also
// updates the per-string state, and then the result register.
`timescale 1ns / 1ps
`default_nettype none

`include "legacy_text_to_codepoint_decoder_assert.svh"

module legacy_text_to_codepoint_decoder
	import ltcd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_wr_data,
	// input channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  text_byte,
	input  wire logic        final_byte,
	// output channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [20:0]      code_point,
	output logic             char_valid,
	output logic             decode_error,
	output logic             string_end
);

	// mode register
	logic [1:0]  mode_q;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        fin_s1;

	// per-string decoder state
	logic [20:0] partial_q;
	logic [1:0]  pend_q;
	logic        cr_q;
	logic        err_q;

	// result register
	logic        valid_s2;
	logic [20:0] cp_s2;
	logic        have_s2;
	logic        err_s2;
	logic        fin_s2;

	// decode step outputs
	logic [20:0] nxt_partial;
	logic [1:0]  nxt_pend;
	logic        nxt_cr;
	logic        nxt_err;
	logic [20:0] dec_cp;
	logic        dec_have;
	logic        do_lead;
	logic [20:0] cont_val;
	logic        adv;

	// handshake: s1 moves on when the result register is free or drained
	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_UTF8;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= text_byte;
			fin_s1  <= final_byte;
		end
	end

	// decode one byte against the current state
	always_comb begin
		nxt_partial = partial_q;
		nxt_pend    = pend_q;
		nxt_err     = err_q;
		nxt_cr      = cr_q;
		dec_cp      = '0;
		dec_have    = 1'b0;
		do_lead     = 1'b0;
		cont_val    = {partial_q[14:0], byte_s1[5:0]};

		if (mode_q == MODE_UTF8) begin
			// continuation or lead byte
			if (pend_q == 2'd0) begin
				do_lead = 1'b1;
			end else if (byte_s1[7:6] != 2'b10) begin
				nxt_err     = 1'b1;
				nxt_pend    = 2'd0;
				nxt_partial = '0;
				do_lead     = 1'b1;
			end else begin
				nxt_pend = pend_q - 2'd1;
				if (pend_q == 2'd1) begin
					dec_cp      = cont_val;
					dec_have    = 1'b1;
					nxt_partial = '0;
				end else begin
					nxt_partial = cont_val;
				end
			end

			if (do_lead) begin
				if (byte_s1 <= 8'h7F) begin
					dec_cp   = {13'd0, byte_s1};
					dec_have = 1'b1;
				end else if (byte_s1 <= 8'hC1) begin
					nxt_err = 1'b1;
				end else if (byte_s1 <= 8'hDF) begin
					nxt_partial = {16'd0, byte_s1[4:0]};
					nxt_pend    = 2'd1;
				end else if (byte_s1 <= 8'hEF) begin
					nxt_partial = {17'd0, byte_s1[3:0]};
					nxt_pend    = 2'd2;
				end else if (byte_s1 <= 8'hF4) begin
					nxt_partial = {18'd0, byte_s1[2:0]};
					nxt_pend    = 2'd3;
				end else begin
					nxt_err = 1'b1;
				end
			end
		end else begin
			// single-byte code pages
			nxt_pend    = 2'd0;
			nxt_partial = '0;
			dec_have    = 1'b1;
			if (!byte_s1[7] || mode_q == MODE_LATIN1) begin
				dec_cp = {13'd0, byte_s1};
			end else if (mode_q == MODE_WIN1252) begin
				if (byte_s1 < 8'hA0) begin
					dec_cp = {5'd0, WIN1252_HI[byte_s1[4:0]]};
				end else begin
					dec_cp = {13'd0, byte_s1};
				end
			end else begin
				dec_cp = {5'd0, MACROMAN_HI[byte_s1[6:0]]};
			end
		end

		// newline normalization
		if (dec_have) begin
			if (cr_q && (dec_cp == CP_LF || dec_cp == CP_NEL)) begin
				dec_have = 1'b0;
				dec_cp   = '0;
				nxt_cr   = 1'b0;
			end else if (dec_cp == CP_CR) begin
				dec_cp = CP_LF;
				nxt_cr = 1'b1;
			end else begin
				if (dec_cp inside {CP_NEL, CP_FF, CP_LS, CP_PS}) begin
					dec_cp = CP_LF;
				end
				nxt_cr = 1'b0;
			end
		end

		// sequence cut off at the end of the string
		if (fin_s1 && nxt_pend != 2'd0) begin
			nxt_err = 1'b1;
		end
	end

	// state update, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			pend_q    <= 2'd0;
			cr_q      <= 1'b0;
			err_q     <= 1'b0;
		end else if (adv) begin
			if (fin_s1) begin
				partial_q <= '0;
				pend_q    <= 2'd0;
				cr_q      <= 1'b0;
				err_q     <= 1'b0;
			end else begin
				partial_q <= nxt_partial;
				pend_q    <= nxt_pend;
				cr_q      <= nxt_cr;
				err_q     <= nxt_err;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cp_s2   <= dec_cp;
			have_s2 <= dec_have;
			err_s2  <= nxt_err;
			fin_s2  <= fin_s1;
		end
	end

	assign out_valid    = valid_s2;
	assign code_point   = cp_s2;
	assign char_valid   = have_s2;
	assign decode_error = err_s2;
	assign string_end   = fin_s2;

	// checks
	`LTCD_ASSERT_IMP(a_no_char_zero, clk, arst_n, valid_s2 && !have_s2, cp_s2 == '0,
		"result without a character carries a nonzero code point")
	`LTCD_ASSERT_IMP(a_nl_normalized, clk, arst_n, valid_s2 && have_s2,
		cp_s2 != CP_CR && cp_s2 != CP_NEL && cp_s2 != CP_FF && cp_s2 != CP_LS
		&& cp_s2 != CP_PS, "newline character left unnormalized")
	`LTCD_ASSERT_NXT(a_state_clear, clk, arst_n, adv && fin_s1,
		pend_q == 2'd0 && !err_q && !cr_q && partial_q == '0,
		"decoder state not cleared after the last byte")
	`LTCD_ASSERT_NXT(a_accept_loads, clk, arst_n, in_valid && in_ready, valid_s1,
		"accepted item not held in the input register")

endmodule

`default_nettype wire
